/* design/lkc_pkg.sv */
// Shared constants and types for the LRU key cache.
// Used by the recency cells, the top level and the port checker.
package lkc_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 64;

    // Fixed port widths
    localparam int KEY_W  = 64;
    localparam int CAP_W  = 5;
    localparam int RANK_W = 4;
    localparam int OCC_W  = 5;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // One link of the recency chain: what a cell hands to its neighbour
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
    } lkc_link_t;

endpackage

/* design/lkc_cell.sv */
// One position of the recency stack: a stored key and its valid bit.
// Depends on lkc_pkg for the link type and key width.
module lkc_cell
    import lkc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  lkc_link_t           link_in,
    input  logic [KEY_BITS-1:0] probe_key,
    output lkc_link_t           link_out,
    output logic                match
);

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    always_comb
    begin
        valid_next = shift ? link_in.valid : valid_reg;
        key_next   = shift ? link_in.key   : key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Keys need no reset: an entry is only read once its valid bit is set
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign link_out.valid = valid_reg;
    assign link_out.key   = key_reg;
    assign match          = valid_reg && (key_reg == probe_key);

endmodule

/* design/lru_key_cache.sv */
// A result strobes on done in the cycle after start is taken.
// Throughput: one lookup per cycle; all cells compare in parallel and the
// chain shifts in the same cycle, so busy stays low.
// Reset clears every valid bit, the occupancy count and sets capacity to 16;
// stored keys are not cleared. Results cannot be stalled by the receiver.
// Top level of the LRU key cache; depends on lkc_pkg and lkc_cell.
module lru_key_cache
    import lkc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KEY_W-1:0]  lookup_key,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data,
    output logic              done,
    output logic              hit,
    output logic              evicted,
    output logic [KEY_W-1:0]  evicted_key,
    output logic [RANK_W-1:0] hit_rank,
    output logic [OCC_W-1:0]  occupancy
);

    logic                take;
    logic [KEY_BITS-1:0] probe_key;

    lkc_link_t           links [DEPTH+1];
    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    shift;
    logic [DEPTH-1:0]    tail;

    logic [CAP_W-1:0]    cap_reg;
    logic [CAP_W-1:0]    cap_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    cap_eff;

    logic                hit_now;
    logic                evict_now;
    logic [IDX_W-1:0]    rank;
    logic [IDX_W-1:0]    top;
    logic [KEY_BITS-1:0] tail_key;

    logic                done_reg;
    logic                hit_reg;
    logic                evicted_reg;
    logic [KEY_W-1:0]    ev_key_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [OCC_W-1:0]    occ_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;
    assign probe_key = lookup_key[KEY_BITS-1:0];

    // Head of the chain: the new key, always valid
    assign links[0].valid = 1'b1;
    assign links[0].key   = probe_key;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        lkc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift[g]),
            .link_in   (links[g]),
            .probe_key (probe_key),
            .link_out  (links[g+1]),
            .match     (match[g])
        );

        // Last valid cell holds the least recent key
        if (g == DEPTH - 1)
        begin : g_last
            assign tail[g] = links[g+1].valid;
        end
        else
        begin : g_mid
            assign tail[g] = links[g+1].valid && !links[g+2].valid;
        end

        assign shift[g] = take && (IDX_W'(g) <= top);
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    always_comb
    begin
        rank = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                rank = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        tail_key = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (tail[i])
            begin
                tail_key = tail_key | links[i+1].key;
            end
        end
    end

    assign hit_now   = |match;
    assign evict_now = !hit_now && (count_reg >= cap_eff) && (count_reg != '0);

    // Deepest cell that moves this cycle
    always_comb
    begin
        if (hit_now)
        begin
            top = rank;
        end
        else if (evict_now)
        begin
            top = IDX_W'(count_reg - 1'b1);
        end
        else if (int'(count_reg) >= DEPTH)
        begin
            top = IDX_W'(DEPTH - 1);
        end
        else
        begin
            top = IDX_W'(count_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (take && !hit_now && !evict_now && (int'(count_reg) < DEPTH))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign cap_next = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
            done_reg  <= take;
        end
    end

    // Result word: capture on every accepted lookup
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hit_reg     <= hit_now;
            evicted_reg <= evict_now;
            ev_key_reg  <= evict_now ? KEY_W'(tail_key) : '0;
            rank_reg    <= hit_now ? RANK_W'(rank) : '0;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = ev_key_reg;
    assign hit_rank    = rank_reg;
    assign occupancy   = occ_reg;

endmodule

/* design/lkc_checker.sv */
// Port-level checks for the LRU key cache, bound to the top level.
// Depends on lkc_pkg for port widths.
module lkc_checker
    import lkc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  logic              hit,
    input  logic              evicted,
    input  logic [KEY_W-1:0]  evicted_key,
    input  logic [RANK_W-1:0] hit_rank,
    input  logic [OCC_W-1:0]  occupancy
);

    // Every taken lookup yields exactly one word in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("lookup taken without a result word");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result word without a lookup");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted) && (occupancy != '0))
        else $error("hit with eviction or empty store after lookup");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (evicted || evicted_key == '0) && (hit || hit_rank == '0))
        else $error("evicted key or rank set without cause");

    // Occupancy never shrinks between words
    a_occ_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done)) |-> (occupancy >= $past(occupancy)))
        else $error("occupancy fell");

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (.*);
